>>> sv/ohlcagg_pkg.sv
`timescale 1ns / 1ps

package ohlcagg_pkg;

   // Field widths of the bar format.
   localparam int PRICE_WIDTH     = 32;
   localparam int STAMP_WIDTH     = 48;
   localparam int VOLUME_IN_WIDTH = 32;
   localparam int VOLUME_WIDTH    = 63;
   localparam int COUNT_WIDTH     = 16;

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Register port.
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_BIT  = 2;

   localparam logic REG_FIRST_WINDOW_LEN    = 1'b0;
   localparam logic REG_SECOND_WINDOW_RATIO = 1'b1;

   localparam logic [COUNT_WIDTH-1:0] FIRST_WINDOW_LEN_RESET    = 16'd60;
   localparam logic [COUNT_WIDTH-1:0] SECOND_WINDOW_RATIO_RESET = 16'd5;

   // Item codes.
   localparam logic REQ_CLEAR    = 1'b1;
   localparam logic LEVEL_FIRST  = 1'b0;
   localparam logic LEVEL_SECOND = 1'b1;

   // Prices at or below this value are rejected.
   localparam logic signed [PRICE_WIDTH-1:0] PRICE_ZERO = '0;

   typedef struct packed {
      logic                          req_type;
      logic signed [PRICE_WIDTH-1:0] open_in;
      logic signed [PRICE_WIDTH-1:0] high_in;
      logic signed [PRICE_WIDTH-1:0] low_in;
      logic signed [PRICE_WIDTH-1:0] close_in;
      logic [VOLUME_IN_WIDTH-1:0]    volume_in;
      logic [STAMP_WIDTH-1:0]        stamp_in;
   } req_item_type;

   typedef struct packed {
      logic                          level;
      logic signed [PRICE_WIDTH-1:0] open_out;
      logic signed [PRICE_WIDTH-1:0] high_out;
      logic signed [PRICE_WIDTH-1:0] low_out;
      logic signed [PRICE_WIDTH-1:0] close_out;
      logic [VOLUME_WIDTH-1:0]       volume_out;
      logic [STAMP_WIDTH-1:0]        stamp_out;
      logic                          last;
   } rsp_item_type;

   typedef struct packed {
      logic signed [PRICE_WIDTH-1:0] open;
      logic signed [PRICE_WIDTH-1:0] high;
      logic signed [PRICE_WIDTH-1:0] low;
      logic signed [PRICE_WIDTH-1:0] close;
      logic [VOLUME_WIDTH-1:0]       volume;
      logic [STAMP_WIDTH-1:0]        stamp;
   } bar_type;

   typedef struct packed {
      logic    clear;
      bar_type bar;
   } cmd_type;

endpackage

>>> sv/ohlcagg_front.sv
`timescale 1ns / 1ps

module ohlcagg_front (
   input  ohlcagg_pkg::req_item_type req_item,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      queue_ready,
   output logic                      push,
   output ohlcagg_pkg::cmd_type      push_cmd
);
   import ohlcagg_pkg::*;

   logic is_clear;
   logic prices_ok;

   // A bar is only kept when all four prices are strictly positive.
   always_comb begin
      is_clear  = (req_item.req_type == REQ_CLEAR);
      prices_ok = ($signed(req_item.open_in) > PRICE_ZERO) &&
                  ($signed(req_item.high_in) > PRICE_ZERO) &&
                  ($signed(req_item.low_in) > PRICE_ZERO) &&
                  ($signed(req_item.close_in) > PRICE_ZERO);

      push_cmd.clear      = is_clear;
      push_cmd.bar.open   = req_item.open_in;
      push_cmd.bar.high   = req_item.high_in;
      push_cmd.bar.low    = req_item.low_in;
      push_cmd.bar.close  = req_item.close_in;
      push_cmd.bar.volume = {{(VOLUME_WIDTH - VOLUME_IN_WIDTH){1'b0}}, req_item.volume_in};
      push_cmd.bar.stamp  = req_item.stamp_in;
   end

   assign req_ready = queue_ready;
   assign push      = req_valid & queue_ready & (is_clear | prices_ok);

endmodule

>>> sv/ohlcagg_queue.sv
`timescale 1ns / 1ps

module ohlcagg_queue #(
   parameter int DEPTH = ohlcagg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ohlcagg_pkg::cmd_type push_cmd,
   output logic                 push_ready,
   output logic                 pop_valid,
   output ohlcagg_pkg::cmd_type pop_cmd,
   input  logic                 pop
);
   import ohlcagg_pkg::*;

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_SLOT  = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_COUNT = CNT_WIDTH'(DEPTH);

   cmd_type              slot_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push & push_ready;
      do_pop    = pop & pop_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> sv/ohlcagg_back.sv
`timescale 1ns / 1ps

module ohlcagg_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [ohlcagg_pkg::COUNT_WIDTH-1:0]     first_window_len,
   input  logic [ohlcagg_pkg::COUNT_WIDTH-1:0]     second_window_ratio,
   input  logic                                    cmd_valid,
   input  ohlcagg_pkg::cmd_type                    cmd,
   output logic                                    cmd_pop,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output ohlcagg_pkg::rsp_item_type               rsp_item
);
   import ohlcagg_pkg::*;

   function automatic logic [VOLUME_WIDTH-1:0] sat_add(input logic [VOLUME_WIDTH-1:0] a,
                                                       input logic [VOLUME_WIDTH-1:0] b);
      logic [VOLUME_WIDTH:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[VOLUME_WIDTH] ? {VOLUME_WIDTH{1'b1}} : sum[VOLUME_WIDTH-1:0];
   endfunction

   // An empty accumulator takes the bar as it is; otherwise the bar is folded in.
   function automatic bar_type merge_bar(input bar_type acc, input bar_type b,
                                         input logic fresh, input logic stamp_follows);
      bar_type r;
      r = acc;
      if (fresh) begin
         r = b;
      end else begin
         if ($signed(b.high) > $signed(acc.high)) begin
            r.high = b.high;
         end
         if ($signed(b.low) < $signed(acc.low)) begin
            r.low = b.low;
         end
         r.close  = b.close;
         r.volume = sat_add(acc.volume, b.volume);
         if (stamp_follows) begin
            r.stamp = b.stamp;
         end
      end
      return r;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] next_count(input logic [COUNT_WIDTH-1:0] c);
      return (c == {COUNT_WIDTH{1'b1}}) ? c : c + 1'b1;
   endfunction

   function automatic rsp_item_type make_rsp(input logic level, input bar_type b,
                                             input logic last);
      rsp_item_type r;
      r.level      = level;
      r.open_out   = b.open;
      r.high_out   = b.high;
      r.low_out    = b.low;
      r.close_out  = b.close;
      r.volume_out = b.volume;
      r.stamp_out  = b.stamp;
      r.last       = last;
      return r;
   endfunction

   // First-level accumulator.
   logic [COUNT_WIDTH-1:0] l1_count_ff, l1_count_in, l1_count_next;
   bar_type                l1_bar_ff, l1_bar_in, l1_merged;
   logic                   l1_full;
   logic                   s1_take;

   // Completed first-level bar (or clear) handed to the second level.
   logic    s2_valid_ff, s2_valid_in;
   logic    s2_clear_ff, s2_clear_in;
   bar_type s2_bar_ff, s2_bar_in;
   logic    s2_pop;

   // Second-level accumulator and output register.
   logic [COUNT_WIDTH-1:0] l2_count_ff, l2_count_in, l2_count_next;
   bar_type                l2_bar_ff, l2_bar_in, l2_merged;
   logic                   l2_full;
   logic                   phase_ff, phase_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_item_type           out_ff, out_in;
   logic                   out_free;
   logic                   out_load;

   always_comb begin
      l2_merged     = merge_bar(l2_bar_ff, s2_bar_ff, l2_count_ff == '0, 1'b1);
      l2_count_next = next_count(l2_count_ff);
      l2_full       = (l2_count_next >= second_window_ratio);
      out_free      = !out_valid_ff | rsp_ready;

      s2_pop      = 1'b0;
      out_load    = 1'b0;
      out_in      = out_ff;
      phase_in    = phase_ff;
      l2_count_in = l2_count_ff;
      l2_bar_in   = l2_bar_ff;

      if (s2_valid_ff) begin
         if (s2_clear_ff) begin
            s2_pop      = 1'b1;
            l2_count_in = '0;
         end else if (out_free) begin
            out_load = 1'b1;
            if (phase_ff) begin
               // Second result of the item: the full second-level bar.
               out_in      = make_rsp(LEVEL_SECOND, l2_bar_ff, 1'b1);
               l2_count_in = '0;
               phase_in    = 1'b0;
               s2_pop      = 1'b1;
            end else begin
               out_in      = make_rsp(LEVEL_FIRST, s2_bar_ff, !l2_full);
               l2_bar_in   = l2_merged;
               l2_count_in = l2_count_next;
               if (l2_full) begin
                  phase_in = 1'b1;
               end else begin
                  s2_pop = 1'b1;
               end
            end
         end
      end

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_comb begin
      l1_merged     = merge_bar(l1_bar_ff, cmd.bar, l1_count_ff == '0, 1'b0);
      l1_count_next = next_count(l1_count_ff);
      l1_full       = (l1_count_next >= first_window_len);
      s1_take       = cmd_valid & (!s2_valid_ff | s2_pop);

      l1_count_in = l1_count_ff;
      l1_bar_in   = l1_bar_ff;
      s2_valid_in = s2_valid_ff & !s2_pop;
      s2_clear_in = s2_clear_ff;
      s2_bar_in   = s2_bar_ff;

      if (s1_take) begin
         if (cmd.clear) begin
            l1_count_in = '0;
            s2_valid_in = 1'b1;
            s2_clear_in = 1'b1;
         end else if (l1_full) begin
            l1_count_in = '0;
            s2_valid_in = 1'b1;
            s2_clear_in = 1'b0;
            s2_bar_in   = l1_merged;
         end else begin
            l1_count_in = l1_count_next;
            l1_bar_in   = l1_merged;
         end
      end
   end

   assign cmd_pop   = s1_take;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_count_ff  <= '0;
         l2_count_ff  <= '0;
         s2_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         l1_count_ff  <= l1_count_in;
         l2_count_ff  <= l2_count_in;
         s2_valid_ff  <= s2_valid_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      l1_bar_ff   <= l1_bar_in;
      l2_bar_ff   <= l2_bar_in;
      s2_clear_ff <= s2_clear_in;
      s2_bar_ff   <= s2_bar_in;
      out_ff      <= out_in;
   end

endmodule

>>> sv/two_level_ohlc_bar_aggregator_core.sv
`timescale 1ns / 1ps

// Two-level OHLC bar aggregator.
// The req channel carries one item per handshake: a price bar or a clear request.
// Bars with any price at or below zero are dropped at the input and cause no result.
// Kept bars merge into a first-level bar; after first_window_len bars it is sent on
// the rsp channel with level 0 and merged into a second-level bar, which is sent
// with level 1 after second_window_ratio first-level bars. The last flag marks the
// final result that an item causes.
// Throughput is one item per cycle while the receiver keeps up; an item that
// completes both levels holds the output until both of its results are sent, one
// per level. On the way to rsp a result passes the command queue, the first-level
// stage and the output register; the level 1 result follows the level 0 result.
// When the receiver stalls, results wait in the output register, the back end
// stops, and the four-entry command queue keeps taking items until it fills.
// Reset empties the queue and both accumulators and loads the window registers
// with 60 and 5. The registers sit on the APB port at byte addresses 0 and 4;
// write them only while the block is idle.
module two_level_ohlc_bar_aggregator_core #(
   parameter int QUEUE_DEPTH = ohlcagg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  ohlcagg_pkg::req_item_type               req_item,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output ohlcagg_pkg::rsp_item_type               rsp_item,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [ohlcagg_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [ohlcagg_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [ohlcagg_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                    pready
);
   import ohlcagg_pkg::*;

   // Window registers.
   logic [COUNT_WIDTH-1:0] first_window_len_ff, first_window_len_in;
   logic [COUNT_WIDTH-1:0] second_window_ratio_ff, second_window_ratio_in;
   logic                   csr_write;

   // Front to queue, queue to back.
   logic    push;
   logic    queue_ready;
   cmd_type push_cmd;
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   // The register port never inserts wait states. Only address bit 2 selects a
   // register, so every address maps onto one of the two.
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_comb begin
      first_window_len_in    = first_window_len_ff;
      second_window_ratio_in = second_window_ratio_ff;
      if (csr_write) begin
         case (paddr[CSR_INDEX_BIT])
            REG_FIRST_WINDOW_LEN: begin
               first_window_len_in = pwdata[COUNT_WIDTH-1:0];
            end
            REG_SECOND_WINDOW_RATIO: begin
               second_window_ratio_in = pwdata[COUNT_WIDTH-1:0];
            end
            default: begin
               first_window_len_in = first_window_len_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[CSR_INDEX_BIT])
         REG_FIRST_WINDOW_LEN: begin
            prdata = {{(CSR_DATA_WIDTH - COUNT_WIDTH){1'b0}}, first_window_len_ff};
         end
         REG_SECOND_WINDOW_RATIO: begin
            prdata = {{(CSR_DATA_WIDTH - COUNT_WIDTH){1'b0}}, second_window_ratio_ff};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_window_len_ff    <= FIRST_WINDOW_LEN_RESET;
         second_window_ratio_ff <= SECOND_WINDOW_RATIO_RESET;
      end else begin
         first_window_len_ff    <= first_window_len_in;
         second_window_ratio_ff <= second_window_ratio_in;
      end
   end

   // The front end screens items and turns them into queue commands.
   ohlcagg_front u_front (
      .req_item    (req_item),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .queue_ready (queue_ready),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   ohlcagg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (queue_ready),
      .pop_valid  (cmd_valid),
      .pop_cmd    (cmd),
      .pop        (cmd_pop)
   );

   // The back end holds both accumulators and the output register.
   ohlcagg_back u_back (
      .clock               (clock),
      .reset               (reset),
      .first_window_len    (first_window_len_ff),
      .second_window_ratio (second_window_ratio_ff),
      .cmd_valid           (cmd_valid),
      .cmd                 (cmd),
      .cmd_pop             (cmd_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_item            (rsp_item)
   );

endmodule
